// ===== rtl/nghbe_pkg.sv =====
`default_nettype none
package nghbe_pkg;

    // build-time defaults
    localparam int DEF_MAX_POS    = 4096;
    localparam int DEF_VOCAB      = 65536;
    localparam int DEF_MAX_NLEN   = 3;
    localparam int DEF_MAX_HEADS  = 8;
    localparam int DEF_MAX_LAYERS = 2;
    localparam int DEF_ID_BITS    = 20;

    // front to back queue depth
    localparam int QUEUE_DEPTH = 2;

    // request kinds
    localparam logic [2:0] REQ_TOKEN  = 3'd0;
    localparam logic [2:0] REQ_MAP    = 3'd1;
    localparam logic [2:0] REQ_MULT   = 3'd2;
    localparam logic [2:0] REQ_PRIME  = 3'd3;
    localparam logic [2:0] REQ_OFFSET = 3'd4;

    // config register indexes
    localparam logic [2:0] CFG_VOCAB_SIZE  = 3'd0;
    localparam logic [2:0] CFG_PAD_ID      = 3'd1;
    localparam logic [2:0] CFG_NGRAM_LEN   = 3'd2;
    localparam logic [2:0] CFG_HEAD_COUNT  = 3'd3;
    localparam logic [2:0] CFG_LAYER_COUNT = 3'd4;

    // config reset values
    localparam logic [16:0] RST_VOCAB_SIZE  = 17'd65536;
    localparam logic [19:0] RST_PAD_ID      = 20'd0;
    localparam logic [1:0]  RST_NGRAM_LEN   = 2'd3;
    localparam logic [3:0]  RST_HEAD_COUNT  = 4'd8;
    localparam logic [1:0]  RST_LAYER_COUNT = 2'd2;

    // clamped run settings
    typedef struct packed {
        logic [16:0] vocab;
        logic [19:0] pad;
        logic [3:0]  ng;
        logic [4:0]  nh;
        logic [3:0]  nl;
    } run_cfg_t;

    // table write from front to back
    typedef struct packed {
        logic        en;
        logic [2:0]  kind;
        logic [15:0] idx;
        logic [62:0] value;
    } tbl_wr_t;

endpackage
`default_nettype wire

// ===== rtl/nghbe_if.sv =====
`default_nettype none
interface nghbe_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] token_id;
    logic [19:0] position;
    logic        alive;
    logic [15:0] table_index;
    logic [62:0] table_value;

    modport source (output valid, output req_type, output token_id, output position,
                    output alive, output table_index, output table_value, input ready);
    modport sink   (input valid, input req_type, input token_id, input position,
                    input alive, input table_index, input table_value, output ready);
endinterface

interface nghbe_out_if;
    logic        valid;
    logic        ready;
    logic        layer_index;
    logic [3:0]  column;
    logic [39:0] bucket;
    logic        status;
    logic        last;

    modport source (output valid, output layer_index, output column, output bucket,
                    output status, output last, input ready);
    modport sink   (input valid, input layer_index, input column, input bucket,
                    input status, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/nghbe_fifo.sv =====
`default_nettype none
module nghbe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/nghbe_front.sv =====
`default_nettype none
module nghbe_front #(
    parameter int MAX_POS  = 4096,
    parameter int VOCAB    = 65536,
    parameter int MAX_NLEN = 3,
    parameter int ID_BITS  = 20,
    parameter int TOK_W    = 20
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    nghbe_in_if.sink                      token_ch,
    input  wire nghbe_pkg::run_cfg_t      cfg,
    input  wire logic                     tbl_free,
    output nghbe_pkg::tbl_wr_t            tbl_wr,
    output logic                          job_valid,
    input  wire logic                     job_ready,
    output logic [MAX_NLEN*TOK_W:0]       job_data
);
    localparam int POS_W = $clog2(MAX_POS);
    localparam int MAP_W = $clog2(VOCAB);
    localparam int SL_W  = $clog2(MAX_NLEN + 1);
    localparam int SI_W  = $clog2(MAX_NLEN);

    typedef enum logic [2:0] {F_CLR, F_IDLE, F_MAP, F_LOOK, F_WAIT, F_PUSH} fstate_t;

    fstate_t            st_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   clr_reg;
    logic               alive_reg;
    logic               raw_ok_reg;
    logic               err_reg;
    logic               blocked_reg;
    logic [SL_W-1:0]    s_reg;
    logic [TOK_W-1:0]   tok_reg [MAX_NLEN];

    logic [ID_BITS-1:0] map_mem [VOCAB];
    logic [ID_BITS-1:0] map_rd_reg;
    logic [ID_BITS:0]   id_mem [MAX_POS];
    logic [ID_BITS:0]   id_rd_reg;

    logic               accept;
    logic               is_tbl;
    logic               beyond;
    logic               raw_ok;
    logic               map_we;
    logic               map_re;
    logic [ID_BITS-1:0] mapped;
    logic               look_ok;
    logic               s_done;
    logic               id_re;
    logic               id_we;
    logic [POS_W-1:0]   id_waddr;
    logic [ID_BITS:0]   id_wdata;
    logic [TOK_W-1:0]   pad_tok;

    always_comb
    begin
        is_tbl = (token_ch.req_type == nghbe_pkg::REQ_MULT)
              || (token_ch.req_type == nghbe_pkg::REQ_PRIME)
              || (token_ch.req_type == nghbe_pkg::REQ_OFFSET);
        // back tables only change while the back end has nothing in flight
        token_ch.ready = (st_reg == F_IDLE) && (!is_tbl || tbl_free);
        accept   = token_ch.valid && token_ch.ready;
        beyond   = {1'b0, token_ch.position} >= 21'(MAX_POS);
        raw_ok   = ({1'b0, token_ch.token_id} < 33'(cfg.vocab))
                && ({1'b0, token_ch.token_id} < 33'(VOCAB));
        map_we   = accept && (token_ch.req_type == nghbe_pkg::REQ_MAP)
                && (21'(token_ch.table_index) < 21'(VOCAB));
        map_re   = accept && (token_ch.req_type == nghbe_pkg::REQ_TOKEN) && raw_ok;
        mapped   = raw_ok_reg ? map_rd_reg : '0;
        pad_tok  = TOK_W'(cfg.pad);

        tbl_wr.en    = accept && is_tbl;
        tbl_wr.kind  = token_ch.req_type;
        tbl_wr.idx   = token_ch.table_index;
        tbl_wr.value = token_ch.table_value;

        look_ok  = !blocked_reg && (pos_reg >= POS_W'(s_reg));
        s_done   = (4'(s_reg) == cfg.ng);
        id_re    = (st_reg == F_LOOK) && !s_done && look_ok;
        id_we    = (st_reg == F_CLR) || (st_reg == F_MAP);
        id_waddr = (st_reg == F_CLR) ? clr_reg : pos_reg;
        id_wdata = (st_reg == F_CLR) ? '0
                 : {alive_reg, (alive_reg ? mapped : {ID_BITS{1'b0}})};

        job_valid = (st_reg == F_PUSH);
        job_data[MAX_NLEN*TOK_W] = err_reg;
        for (int j = 0; j < MAX_NLEN; j++)
        begin
            job_data[j*TOK_W +: TOK_W] = tok_reg[j];
        end
    end

    // token map, one port
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[MAP_W'(token_ch.table_index)] <= token_ch.table_value[ID_BITS-1:0];
        end
        else if (map_re)
        begin
            map_rd_reg <= map_mem[token_ch.token_id[MAP_W-1:0]];
        end
    end

    // id store: {valid, id}, one port
    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[id_waddr] <= id_wdata;
        end
        else if (id_re)
        begin
            id_rd_reg <= id_mem[pos_reg - POS_W'(s_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= F_CLR;
            clr_reg     <= '0;
            s_reg       <= '0;
            blocked_reg <= 1'b0;
            err_reg     <= 1'b0;
        end
        else
        begin
            case (st_reg)
                F_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == POS_W'(MAX_POS - 1))
                    begin
                        st_reg <= F_IDLE;
                    end
                end
                F_IDLE:
                begin
                    if (accept && (token_ch.req_type == nghbe_pkg::REQ_TOKEN))
                    begin
                        pos_reg    <= token_ch.position[POS_W-1:0];
                        alive_reg  <= token_ch.alive;
                        raw_ok_reg <= raw_ok;
                        err_reg    <= beyond;
                        st_reg     <= beyond ? F_PUSH : F_MAP;
                    end
                end
                F_MAP:
                begin
                    // slot 0 is the token itself
                    tok_reg[0]  <= alive_reg ? TOK_W'(mapped) : pad_tok;
                    blocked_reg <= !alive_reg;
                    s_reg       <= SL_W'(1);
                    st_reg      <= F_LOOK;
                end
                F_LOOK:
                begin
                    if (s_done)
                    begin
                        st_reg <= F_PUSH;
                    end
                    else if (id_re)
                    begin
                        st_reg <= F_WAIT;
                    end
                    else
                    begin
                        tok_reg[s_reg[SI_W-1:0]] <= pad_tok;
                        blocked_reg <= 1'b1;
                        s_reg       <= s_reg + 1'b1;
                    end
                end
                F_WAIT:
                begin
                    if (id_rd_reg[ID_BITS])
                    begin
                        tok_reg[s_reg[SI_W-1:0]] <= TOK_W'(id_rd_reg[ID_BITS-1:0]);
                    end
                    else
                    begin
                        tok_reg[s_reg[SI_W-1:0]] <= pad_tok;
                        blocked_reg <= 1'b1;
                    end
                    s_reg  <= s_reg + 1'b1;
                    st_reg <= F_LOOK;
                end
                F_PUSH:
                begin
                    if (job_ready)
                    begin
                        st_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= F_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/nghbe_back.sv =====
`default_nettype none
module nghbe_back #(
    parameter int MAX_NLEN   = 3,
    parameter int MAX_HEADS  = 8,
    parameter int MAX_LAYERS = 2,
    parameter int TOK_W      = 20
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire nghbe_pkg::run_cfg_t      cfg,
    input  wire nghbe_pkg::tbl_wr_t       tbl_wr,
    input  wire logic                     job_valid,
    output logic                          job_ready,
    input  wire logic [MAX_NLEN*TOK_W:0]  job_data,
    output logic                          idle,
    nghbe_out_if.source                   bucket_ch
);
    localparam int MULT_D = MAX_LAYERS * MAX_NLEN;
    localparam int TBL_D  = MAX_LAYERS * (MAX_NLEN - 1) * MAX_HEADS;
    localparam int COL_D  = (MAX_NLEN - 1) * MAX_HEADS;
    localparam int MW     = $clog2(MULT_D);
    localparam int TW     = (TBL_D > 1) ? $clog2(TBL_D) : 1;
    localparam int CW     = (COL_D > 1) ? $clog2(COL_D) : 1;
    localparam int LW     = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int HW     = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
    localparam int IW     = $clog2(MAX_NLEN);

    typedef enum logic [2:0] {B_IDLE, B_MRD, B_MUL, B_ACC, B_PRD, B_DIV, B_RES, B_OUT}
        bstate_t;

    logic [62:0]      mult_mem [MULT_D];
    logic [39:0]      prime_mem [TBL_D];
    logic [39:0]      off_mem [TBL_D];
    logic [62:0]      mult_rd_reg;
    logic [39:0]      prime_rd_reg;
    logic [39:0]      off_rd_reg;

    bstate_t          st_reg;
    logic             err_reg;
    logic [TOK_W-1:0] tok_reg [MAX_NLEN];
    logic [LW-1:0]    l_reg;
    logic [IW-1:0]    i_reg;
    logic [HW-1:0]    h_reg;
    logic [CW-1:0]    col_reg;
    logic [TW-1:0]    k_reg;
    logic [MW-1:0]    midx_reg;
    logic [TOK_W+31:0] prod_lo_reg;
    logic [TOK_W+30:0] prod_hi_reg;
    logic [63:0]      hash_reg;
    logic [63:0]      hash_next;
    logic [63:0]      sh_reg;
    logic [39:0]      rem_reg;
    logic [5:0]       step_reg;
    logic [40:0]      trial;
    logic [39:0]      rem_next;
    logic [39:0]      rem_fin;
    logic             last_h;
    logic             last_i;
    logic             last_l;

    logic             out_layer_reg;
    logic [3:0]       out_col_reg;
    logic [39:0]      out_bucket_reg;
    logic             out_status_reg;
    logic             out_last_reg;

    always_comb
    begin
        idle      = (st_reg == B_IDLE);
        job_ready = idle;
        hash_next = hash_reg ^ (64'(prod_lo_reg) + 64'({prod_hi_reg, 32'd0}));
        // one restoring step: shift in the next hash bit
        trial     = {rem_reg, sh_reg[63]};
        rem_next  = (trial >= {1'b0, prime_rd_reg}) ? 40'(trial - {1'b0, prime_rd_reg})
                                                   : trial[39:0];
        rem_fin   = (prime_rd_reg == '0) ? hash_reg[39:0] : rem_reg;
        last_h    = (5'(h_reg) == cfg.nh - 5'd1);
        last_i    = (4'(i_reg) == cfg.ng - 4'd1);
        last_l    = (4'(l_reg) == cfg.nl - 4'd1);

        bucket_ch.valid       = (st_reg == B_OUT);
        bucket_ch.layer_index = out_layer_reg;
        bucket_ch.column      = out_col_reg;
        bucket_ch.bucket      = out_bucket_reg;
        bucket_ch.status      = out_status_reg;
        bucket_ch.last        = out_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr.en && (tbl_wr.kind == nghbe_pkg::REQ_MULT)
            && (17'(tbl_wr.idx) < 17'(MULT_D)))
        begin
            mult_mem[tbl_wr.idx[MW-1:0]] <= tbl_wr.value;
        end
        mult_rd_reg <= mult_mem[midx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr.en && (tbl_wr.kind == nghbe_pkg::REQ_PRIME)
            && (17'(tbl_wr.idx) < 17'(TBL_D)))
        begin
            prime_mem[tbl_wr.idx[TW-1:0]] <= tbl_wr.value[39:0];
        end
        prime_rd_reg <= prime_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr.en && (tbl_wr.kind == nghbe_pkg::REQ_OFFSET)
            && (17'(tbl_wr.idx) < 17'(TBL_D)))
        begin
            off_mem[tbl_wr.idx[TW-1:0]] <= tbl_wr.value[39:0];
        end
        off_rd_reg <= off_mem[k_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= B_IDLE;
            err_reg  <= 1'b0;
            l_reg    <= '0;
            i_reg    <= '0;
            h_reg    <= '0;
            col_reg  <= '0;
            k_reg    <= '0;
            midx_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            case (st_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        err_reg <= job_data[MAX_NLEN*TOK_W];
                        for (int j = 0; j < MAX_NLEN; j++)
                        begin
                            tok_reg[j] <= job_data[j*TOK_W +: TOK_W];
                        end
                        l_reg    <= '0;
                        i_reg    <= '0;
                        h_reg    <= '0;
                        col_reg  <= '0;
                        k_reg    <= '0;
                        midx_reg <= '0;
                        hash_reg <= '0;
                        if (job_data[MAX_NLEN*TOK_W])
                        begin
                            out_layer_reg  <= 1'b0;
                            out_col_reg    <= '0;
                            out_bucket_reg <= '0;
                            out_status_reg <= 1'b1;
                            out_last_reg   <= 1'b1;
                            st_reg         <= B_OUT;
                        end
                        else
                        begin
                            st_reg <= B_MRD;
                        end
                    end
                end
                B_MRD:
                begin
                    st_reg <= B_MUL;
                end
                B_MUL:
                begin
                    prod_lo_reg <= tok_reg[i_reg] * mult_rd_reg[31:0];
                    prod_hi_reg <= tok_reg[i_reg] * mult_rd_reg[62:32];
                    st_reg      <= B_ACC;
                end
                B_ACC:
                begin
                    hash_reg <= hash_next;
                    midx_reg <= midx_reg + 1'b1;
                    if (i_reg == '0)
                    begin
                        i_reg  <= IW'(1);
                        st_reg <= B_MRD;
                    end
                    else
                    begin
                        st_reg <= B_PRD;
                    end
                end
                B_PRD:
                begin
                    sh_reg   <= hash_reg;
                    rem_reg  <= '0;
                    step_reg <= '0;
                    st_reg   <= B_DIV;
                end
                B_DIV:
                begin
                    rem_reg  <= rem_next;
                    sh_reg   <= {sh_reg[62:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd63)
                    begin
                        st_reg <= B_RES;
                    end
                end
                B_RES:
                begin
                    out_layer_reg  <= l_reg[0];
                    out_col_reg    <= 4'(col_reg);
                    out_bucket_reg <= rem_fin + off_rd_reg;
                    out_status_reg <= 1'b0;
                    out_last_reg   <= last_h && last_i && last_l;
                    st_reg         <= B_OUT;
                end
                B_OUT:
                begin
                    if (bucket_ch.ready)
                    begin
                        if (err_reg)
                        begin
                            st_reg <= B_IDLE;
                        end
                        else
                        begin
                            k_reg   <= k_reg + 1'b1;
                            col_reg <= col_reg + 1'b1;
                            if (!last_h)
                            begin
                                h_reg  <= h_reg + 1'b1;
                                st_reg <= B_PRD;
                            end
                            else
                            begin
                                h_reg <= '0;
                                if (!last_i)
                                begin
                                    i_reg  <= i_reg + 1'b1;
                                    st_reg <= B_MRD;
                                end
                                else if (last_l)
                                begin
                                    st_reg <= B_IDLE;
                                end
                                else
                                begin
                                    l_reg    <= l_reg + 1'b1;
                                    i_reg    <= '0;
                                    col_reg  <= '0;
                                    hash_reg <= '0;
                                    st_reg   <= B_MRD;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    st_reg <= B_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ngram_hash_bucket_engine_unit.sv =====
`default_nettype none
// N-gram hash bucket engine. Requests on token_ch either load a table (token
// map, per-layer multipliers, primes, bucket offsets) or carry a token. A token
// is mapped to its compressed id, stored at its position (or marked dead), and
// the engine looks back ngram_len - 1 slots, padding from the sequence start or
// the first dead slot on. Per layer it XORs id*multiplier terms (64-bit wrap)
// and, for each n-gram length and head, returns (hash mod prime) + offset on
// bucket_ch, with last set on the token's final bucket. A position past the
// store gives a single result with status set. Config registers sit on the
// APB port at byte 4*index; the user must write them only while the engine is
// idle, as the block itself does not enforce this. After reset the id store is
// swept dead, one entry per cycle, through all MAX_POS entries (4096 by default)
// before the first request is taken. The front end takes one request at a
// time; a token is mapped, stored and its history read before the next is taken,
// and its job is queued for the back end. The back end takes one job at a time;
// each bucket passes the shared restoring remainder unit that retires one hash
// bit per cycle. A full token (2 layers, trigrams, 8 heads) gives 32 buckets.
// Multiplier, prime and offset writes wait until the back end is drained.
module ngram_hash_bucket_engine_unit #(
    parameter int MAX_POS    = nghbe_pkg::DEF_MAX_POS,
    parameter int VOCAB      = nghbe_pkg::DEF_VOCAB,
    parameter int MAX_NLEN   = nghbe_pkg::DEF_MAX_NLEN,
    parameter int MAX_HEADS  = nghbe_pkg::DEF_MAX_HEADS,
    parameter int MAX_LAYERS = nghbe_pkg::DEF_MAX_LAYERS,
    parameter int ID_BITS    = nghbe_pkg::DEF_ID_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    nghbe_in_if.sink         token_ch,
    nghbe_out_if.source      bucket_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    // token values carry pad_id too, so never narrower than it
    localparam int TOK_W = (ID_BITS > 20) ? ID_BITS : 20;
    localparam int JOB_W = MAX_NLEN * TOK_W + 1;

    logic [16:0] vocab_size_reg;
    logic [19:0] pad_id_reg;
    logic [1:0]  ngram_len_reg;
    logic [3:0]  head_count_reg;
    logic [1:0]  layer_count_reg;

    nghbe_pkg::run_cfg_t run_cfg;
    nghbe_pkg::tbl_wr_t  tbl_wr;

    logic             cfg_wr;
    logic [2:0]       cfg_idx;
    logic             back_idle;
    logic             tbl_free;
    logic             push_valid;
    logic             push_ready;
    logic [JOB_W-1:0] push_data;
    logic             pop_valid;
    logic             pop_ready;
    logic [JOB_W-1:0] pop_data;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vocab_size_reg  <= nghbe_pkg::RST_VOCAB_SIZE;
            pad_id_reg      <= nghbe_pkg::RST_PAD_ID;
            ngram_len_reg   <= nghbe_pkg::RST_NGRAM_LEN;
            head_count_reg  <= nghbe_pkg::RST_HEAD_COUNT;
            layer_count_reg <= nghbe_pkg::RST_LAYER_COUNT;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                nghbe_pkg::CFG_VOCAB_SIZE:  vocab_size_reg  <= pwdata[16:0];
                nghbe_pkg::CFG_PAD_ID:      pad_id_reg      <= pwdata[19:0];
                nghbe_pkg::CFG_NGRAM_LEN:   ngram_len_reg   <= pwdata[1:0];
                nghbe_pkg::CFG_HEAD_COUNT:  head_count_reg  <= pwdata[3:0];
                nghbe_pkg::CFG_LAYER_COUNT: layer_count_reg <= pwdata[1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            nghbe_pkg::CFG_VOCAB_SIZE:  prdata = 32'(vocab_size_reg);
            nghbe_pkg::CFG_PAD_ID:      prdata = 32'(pad_id_reg);
            nghbe_pkg::CFG_NGRAM_LEN:   prdata = 32'(ngram_len_reg);
            nghbe_pkg::CFG_HEAD_COUNT:  prdata = 32'(head_count_reg);
            nghbe_pkg::CFG_LAYER_COUNT: prdata = 32'(layer_count_reg);
            default:                    prdata = '0;
        endcase
    end

    // saturate counts to what the hardware was built for
    always_comb
    begin
        run_cfg.vocab = vocab_size_reg;
        run_cfg.pad   = pad_id_reg;
        if (4'(ngram_len_reg) < 4'd2)
            run_cfg.ng = 4'd2;
        else if (4'(ngram_len_reg) > 4'(MAX_NLEN))
            run_cfg.ng = 4'(MAX_NLEN);
        else
            run_cfg.ng = 4'(ngram_len_reg);
        if (5'(head_count_reg) < 5'd1)
            run_cfg.nh = 5'd1;
        else if (5'(head_count_reg) > 5'(MAX_HEADS))
            run_cfg.nh = 5'(MAX_HEADS);
        else
            run_cfg.nh = 5'(head_count_reg);
        if (4'(layer_count_reg) < 4'd1)
            run_cfg.nl = 4'd1;
        else if (4'(layer_count_reg) > 4'(MAX_LAYERS))
            run_cfg.nl = 4'(MAX_LAYERS);
        else
            run_cfg.nl = 4'(layer_count_reg);
    end

    assign tbl_free = back_idle && !pop_valid;

    nghbe_front #(
        .MAX_POS   (MAX_POS),
        .VOCAB     (VOCAB),
        .MAX_NLEN  (MAX_NLEN),
        .ID_BITS   (ID_BITS),
        .TOK_W     (TOK_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .token_ch  (token_ch),
        .cfg       (run_cfg),
        .tbl_free  (tbl_free),
        .tbl_wr    (tbl_wr),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job_data  (push_data)
    );

    nghbe_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (nghbe_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    nghbe_back #(
        .MAX_NLEN   (MAX_NLEN),
        .MAX_HEADS  (MAX_HEADS),
        .MAX_LAYERS (MAX_LAYERS),
        .TOK_W      (TOK_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (run_cfg),
        .tbl_wr    (tbl_wr),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job_data  (pop_data),
        .idle      (back_idle),
        .bucket_ch (bucket_ch)
    );
endmodule
`default_nettype wire

// ===== rtl/nghbe_chk.sv =====
`default_nettype none
module nghbe_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_layer,
    input wire logic [3:0]  out_column,
    input wire logic [39:0] out_bucket,
    input wire logic        out_status,
    input wire logic        out_last,
    input wire logic        pready
);
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_bucket)
                                     && $stable(out_column) && $stable(out_last))
        else $error("bucket result changed while stalled");

    // an error result must carry last (it is the only result of its request)
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status |-> out_last)
        else $error("error result without last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status |-> out_bucket == '0 && out_column == '0 && !out_layer)
        else $error("error result carries nonzero fields");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");
endmodule

bind ngram_hash_bucket_engine_unit nghbe_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (bucket_ch.valid),
    .out_ready  (bucket_ch.ready),
    .out_layer  (bucket_ch.layer_index),
    .out_column (bucket_ch.column),
    .out_bucket (bucket_ch.bucket),
    .out_status (bucket_ch.status),
    .out_last   (bucket_ch.last),
    .pready     (pready)
);
`default_nettype wire
